// File: src/fhm_pkg.sv
// Package for the FIFO hand-off mutex: sizes, result codes and the
// controller/datapath interface types. No dependencies.
`timescale 1ns / 1ps

package fhm_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam int PID_W    = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACQUIRED  = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_FREED     = 3'd2,
        ST_HANDOVER  = 3'd3,
        ST_NOT_OWNER = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef enum logic {
        KIND_LOCK   = 1'b0,
        KIND_UNLOCK = 1'b1
    } t_kind;

    typedef struct packed {
        logic load;   // capture request, read queue head
        logic exec;   // apply request, load result register
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_dp_stat;

endpackage

// File: src/fifo_handoff_mutex_core.sv
// Top level of the FIFO hand-off mutex: joins controller and datapath.
// Depends on fhm_pkg, fhm_ctrl and fhm_dp.
`timescale 1ns / 1ps
//
// One mutex with a first-in first-out queue of waiting process IDs.
// Request channel: i_valid / o_stall with i_kind (0 lock, 1 unlock) and
// i_process_id. Result channel: o_valid / i_stall with o_status,
// o_woken_id, o_owner_id, o_is_locked and o_waiter_count.
// A transfer happens on a rising edge with valid high and stall low.
// Each request gives exactly one result.
// The controller captures the request and reads the queue head on its
// transfer, then applies it and loads the result register, which waits
// only while a stalled result still holds the result register. o_stall
// stays high until the request is applied, so no new request is taken
// before the last one has been applied.
// The result register decouples the sides: a new request is taken while a
// result still waits, but that request's execute step waits while the
// receiver stalls and the register is full, holding o_stall high.
// Reset (synchronous, active low) frees the mutex, clears owner, pointers
// and count and drops o_valid. Queue entries are not cleared; they are
// only read after being written.
//
module fifo_handoff_mutex_core
    import fhm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_kind,
    input  logic [PID_W-1:0]    i_process_id,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [PID_W-1:0]    o_woken_id,
    output logic [PID_W-1:0]    o_owner_id,
    output logic                o_is_locked,
    output logic [COUNT_W-1:0]  o_waiter_count
);

    t_cmd     cmd;
    t_dp_stat stat;

    fhm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    fhm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_kind         (i_kind),
        .i_process_id   (i_process_id),
        .i_stall        (i_stall),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_woken_id     (o_woken_id),
        .o_owner_id     (o_owner_id),
        .o_is_locked    (o_is_locked),
        .o_waiter_count (o_waiter_count)
    );

endmodule

// File: src/fhm_ctrl.sv
// Controller for the FIFO hand-off mutex: sequences capture and execute.
// Depends on fhm_pkg.
`timescale 1ns / 1ps

module fhm_ctrl
    import fhm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_stall,
    input  t_dp_stat i_stat,
    output logic     o_stall,
    output t_cmd     o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_stall    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_stat.out_full || !i_stall) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/fhm_dp.sv
// Datapath for the FIFO hand-off mutex: owner state, wait queue memory,
// pointers and the result register. Depends on fhm_pkg.
`timescale 1ns / 1ps

module fhm_dp
    import fhm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic                i_kind,
    input  logic [PID_W-1:0]    i_process_id,
    input  logic                i_stall,
    output t_dp_stat            o_stat,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [PID_W-1:0]    o_woken_id,
    output logic [PID_W-1:0]    o_owner_id,
    output logic                o_is_locked,
    output logic [COUNT_W-1:0]  o_waiter_count
);

    logic [ID_BITS-1:0] r_queue [QUEUE_DEPTH];

    logic                r_held,   n_held;
    logic [ID_BITS-1:0]  r_owner,  n_owner;
    logic [PTR_BITS-1:0] r_head,   n_head;
    logic [PTR_BITS-1:0] r_tail,   n_tail;
    logic [CNT_BITS-1:0] r_waiting, n_waiting;

    t_kind               r_kind;
    logic [ID_BITS-1:0]  r_pid;
    logic [ID_BITS-1:0]  r_head_data;

    logic                r_out_valid;
    t_status             r_status,  n_status;
    logic [ID_BITS-1:0]  r_woken,   n_woken;

    logic we;

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_comb begin
        n_held    = r_held;
        n_owner   = r_owner;
        n_head    = r_head;
        n_tail    = r_tail;
        n_waiting = r_waiting;
        n_woken   = '0;
        n_status  = ST_NOT_OWNER;
        we        = 1'b0;
        unique case (r_kind)
            KIND_LOCK: begin
                if (!r_held) begin
                    n_held   = 1'b1;
                    n_owner  = r_pid;
                    n_status = ST_ACQUIRED;
                end else if (r_waiting == CNT_BITS'(QUEUE_DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    we        = 1'b1;
                    n_tail    = ptr_inc(r_tail);
                    n_waiting = r_waiting + 1'b1;
                    n_status  = ST_QUEUED;
                end
            end
            KIND_UNLOCK: begin
                if (!r_held || r_owner != r_pid) begin
                    n_status = ST_NOT_OWNER;
                end else if (r_waiting == '0) begin
                    n_held   = 1'b0;
                    n_owner  = '0;
                    n_status = ST_FREED;
                end else begin
                    n_woken   = r_head_data;
                    n_owner   = r_head_data;
                    n_head    = ptr_inc(r_head);
                    n_waiting = r_waiting - 1'b1;
                    n_status  = ST_HANDOVER;
                end
            end
            default: begin
                n_status = ST_NOT_OWNER;
            end
        endcase
    end

    // queue memory: write at tail on execute, registered read of head on capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && we) begin
            r_queue[r_tail] <= r_pid;
        end
        if (i_cmd.load) begin
            r_head_data <= r_queue[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= t_kind'(i_kind);
            r_pid  <= ID_BITS'(i_process_id);
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_woken  <= n_woken;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= 1'b0;
            r_owner     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_waiting   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_held    <= n_held;
                r_owner   <= n_owner;
                r_head    <= n_head;
                r_tail    <= n_tail;
                r_waiting <= n_waiting;
            end
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_full = r_out_valid;
    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_woken_id      = PID_W'(r_woken);
    assign o_owner_id      = PID_W'(r_owner);
    assign o_is_locked     = r_held;
    assign o_waiter_count  = COUNT_W'(r_waiting);

endmodule

// File: src/fhm_checker.sv
// Port-level checks for the FIFO hand-off mutex, bound to the top level.
// Depends on fhm_pkg and fifo_handoff_mutex_core.
`timescale 1ns / 1ps

module fhm_checker
    import fhm_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input logic [STATUS_W-1:0] o_status,
    input logic [PID_W-1:0]    o_woken_id,
    input logic [PID_W-1:0]    o_owner_id,
    input logic                o_is_locked,
    input logic [COUNT_W-1:0]  o_waiter_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_woken_id)
            && $stable(o_owner_id) && $stable(o_waiter_count))
        else $error("result changed while stalled");

    a_free_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_locked |-> o_owner_id == '0 && o_waiter_count == '0)
        else $error("free mutex with owner or waiters");

    a_woken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_HANDOVER |-> o_woken_id == '0)
        else $error("woken id outside handover");

    a_handover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_HANDOVER |-> o_is_locked && o_owner_id == o_woken_id)
        else $error("handover did not pass ownership");

    a_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_ACQUIRED || o_status == ST_QUEUED
            || o_status == ST_FULL) |-> o_is_locked)
        else $error("lock result with mutex free");

endmodule

bind fifo_handoff_mutex_core fhm_checker u_fhm_checker (.*);
